// ----- hw/rtl/slc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache model.
package slc_pkg;

  localparam int TAG_W      = 63;
  localparam int CNT_W      = 32;
  localparam int ADDR_W     = 64;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int BLOCK_MAX  = 16;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic             last;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] eviction_count;
  } out_t;

endpackage

// ----- hw/rtl/slc_queue.sv -----
// Two-entry queue between the classifying front and the access back end.
module slc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] ent_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  assign dout  = ent_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Hold entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

endmodule

// ----- hw/rtl/slc_front.sv -----
// Front end: configuration registers, item acceptance and address split.
module slc_front #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8,
  parameter int SW       = 8,
  parameter int WW       = 4,
  parameter int EW       = 76
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  slc_pkg::in_t                     in_data,
  input  logic                             cfg_valid,
  input  logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             q_full,
  input  logic                             clearing,
  output logic                             push,
  output logic [EW-1:0]                    push_entry
);

  localparam int SMAX = $clog2(MAX_SETS + 1) - 1;

  logic [3:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_r;

  logic [3:0]                  s_eff;
  logic [4:0]                  b_eff;
  logic [WW-1:0]               w_eff;
  logic [slc_pkg::ADDR_W-1:0]  shifted;
  logic [SW-1:0]               set_idx;
  logic [slc_pkg::TAG_W-1:0]   tag;
  logic                        two;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 4'd4;
      block_bits_r <= 5'd4;
      ways_r       <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slc_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_data[3:0];
        slc_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_data;
        slc_pkg::CFG_WAYS_USED:  ways_r       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry
  always_comb begin
    s_eff = set_bits_r;
    if (set_bits_r == 4'd0) begin
      s_eff = 4'd1;
    end else if (int'(set_bits_r) > SMAX) begin
      s_eff = 4'(SMAX);
    end
    b_eff = block_bits_r;
    if (block_bits_r == 5'd0) begin
      b_eff = 5'd1;
    end else if (int'(block_bits_r) > slc_pkg::BLOCK_MAX) begin
      b_eff = 5'(slc_pkg::BLOCK_MAX);
    end
    w_eff = WW'(ways_r);
    if (ways_r == 4'd0) begin
      w_eff = WW'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      w_eff = WW'(MAX_WAYS);
    end
  end

  // Split the address into set index and tag
  assign shifted = in_data.address >> b_eff;
  assign set_idx = SW'(shifted & ((64'd1 << s_eff) - 64'd1));
  assign tag     = slc_pkg::TAG_W'(in_data.address >> (6'(s_eff) + 6'(b_eff)));
  assign two     = (in_data.kind == slc_pkg::KIND_MODIFY);

  assign busy       = q_full || clearing;
  assign push       = start && !busy && (in_data.kind != slc_pkg::KIND_UNUSED);
  assign push_entry = {two, w_eff, set_idx, tag};

endmodule

// ----- hw/rtl/slc_back.sv -----
// Back end: set memory, LRU lookup and update, running counters.
module slc_back #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8,
  parameter int AGE_BITS = 32,
  parameter int SW       = 8,
  parameter int WW       = 4,
  parameter int EW       = 76
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [EW-1:0] q_entry,
  output logic          pop,
  output logic          clearing,
  output logic          out_valid,
  output slc_pkg::out_t out_data
);

  localparam int TW = slc_pkg::TAG_W;
  localparam int VW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                v;
    logic [MAX_WAYS-1:0][TW-1:0]        tg;
    logic [MAX_WAYS-1:0][AGE_BITS-1:0]  ag;
  } row_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CALC} state_t;

  row_t mem [MAX_SETS];
  row_t rd_row_r;
  row_t bypass_r;

  state_t                      state_r;
  logic [SW-1:0]               clr_cnt_r;
  logic [TW-1:0]               cur_tag_r;
  logic [SW-1:0]               cur_set_r;
  logic [WW-1:0]               cur_ways_r;
  logic                        cur_two_r;
  logic                        second_r;
  logic [slc_pkg::CNT_W-1:0]   hits_r;
  logic [slc_pkg::CNT_W-1:0]   misses_r;
  logic [slc_pkg::CNT_W-1:0]   evicts_r;
  logic                        out_valid_r;
  slc_pkg::out_t               out_data_r;

  logic [slc_pkg::CNT_W-1:0]   hits_nxt;
  logic [slc_pkg::CNT_W-1:0]   misses_nxt;
  logic [slc_pkg::CNT_W-1:0]   evicts_nxt;

  row_t                        src;
  row_t                        new_row;
  logic                        found;
  logic                        have_inv;
  logic                        have_old;
  logic [VW-1:0]               victim;
  logic [AGE_BITS-1:0]         eldest;
  logic [AGE_BITS-1:0]         age_n;
  logic                        evict;
  logic                        last;

  logic                        we;
  logic [SW-1:0]               wa;
  row_t                        wd;

  assign clearing  = (state_r == ST_CLEAR);
  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Look up the set and build its updated row
  always_comb begin
    src      = second_r ? bypass_r : rd_row_r;
    new_row  = src;
    found    = 1'b0;
    have_inv = 1'b0;
    have_old = 1'b0;
    victim   = '0;
    eldest   = '0;
    age_n    = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (WW'(j) < cur_ways_r) begin
        if (!src.v[j]) begin
          victim   = VW'(j);
          have_inv = 1'b1;
        end else if (src.tg[j] == cur_tag_r) begin
          new_row.ag[j] = '0;
          found         = 1'b1;
        end else begin
          age_n = src.ag[j];
          if (src.ag[j] != '1) begin
            age_n = src.ag[j] + 1'b1;
          end
          new_row.ag[j] = age_n;
          if (!have_inv && (!have_old || (age_n > eldest))) begin
            victim   = VW'(j);
            eldest   = age_n;
            have_old = 1'b1;
          end
        end
      end
    end
    if (!found) begin
      new_row.v[victim]  = 1'b1;
      new_row.tg[victim] = cur_tag_r;
      new_row.ag[victim] = '0;
    end
    evict = !found && !have_inv;
    last  = !(cur_two_r && !second_r);
  end

  // Saturating counters
  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (found) begin
      if (hits_r != '1) hits_nxt = hits_r + 1'b1;
    end else begin
      if (misses_r != '1) misses_nxt = misses_r + 1'b1;
      if (evict && (evicts_r != '1)) evicts_nxt = evicts_r + 1'b1;
    end
  end

  // Select memory write: clearing sweep or row update
  always_comb begin
    we = 1'b0;
    wa = cur_set_r;
    wd = new_row;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else if (state_r == ST_CALC) begin
      we = 1'b1;
    end
  end

  // Set memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_row_r <= mem[q_entry[TW+SW-1:TW]];
    end
  end

  // Sequencer: clear, fetch, update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      second_r    <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SW'(MAX_SETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            cur_tag_r  <= q_entry[TW-1:0];
            cur_set_r  <= q_entry[TW+SW-1:TW];
            cur_ways_r <= q_entry[TW+SW+WW-1:TW+SW];
            cur_two_r  <= q_entry[EW-1];
            second_r   <= 1'b0;
            state_r    <= ST_CALC;
          end
        end
        ST_CALC: begin
          out_valid_r                <= 1'b1;
          out_data_r.hit             <= found;
          out_data_r.evicted         <= evict;
          out_data_r.last            <= last;
          out_data_r.hit_count       <= hits_nxt;
          out_data_r.miss_count      <= misses_nxt;
          out_data_r.eviction_count  <= evicts_nxt;
          hits_r                     <= hits_nxt;
          misses_r                   <= misses_nxt;
          evicts_r                   <= evicts_nxt;
          bypass_r                   <= new_row;
          if (last) begin
            state_r <= ST_IDLE;
          end else begin
            second_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/set_assoc_lru_cache_sim.sv -----
// Top level of the set-associative LRU cache model.
// After reset the block clears all MAX_SETS sets of its memory, one set a cycle,
// with busy high. For each load or store the back end then reads the set's row,
// then updates and writes it back; a modify does so twice, its second access
// reusing the updated row. Results appear on out_valid in the cycle after each
// update. A two-entry queue lets start be taken while the back end works, so busy
// is high only while clearing or when the queue is full. Kind 3 is taken and
// dropped. The receiver cannot stall; configuration writes are always ready.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8,
  parameter int AGE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  slc_pkg::in_t                    in_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  output slc_pkg::out_t                   out_data
);

  localparam int SW = $clog2(MAX_SETS);
  localparam int WW = $clog2(MAX_WAYS + 1);
  localparam int EW = 1 + WW + SW + slc_pkg::TAG_W;

  logic          q_full;
  logic          q_empty;
  logic          clearing;
  logic          push;
  logic          pop;
  logic [EW-1:0] push_entry;
  logic [EW-1:0] q_entry;

  assign cfg_ready = 1'b1;

  slc_front #(
    .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .SW(SW), .WW(WW), .EW(EW)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(q_full), .clearing(clearing), .push(push), .push_entry(push_entry)
  );

  slc_queue #(.W(EW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .din(push_entry), .pop(pop),
    .dout(q_entry), .empty(q_empty), .full(q_full)
  );

  slc_back #(
    .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .AGE_BITS(AGE_BITS),
    .SW(SW), .WW(WW), .EW(EW)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_entry(q_entry), .pop(pop),
    .clearing(clearing), .out_valid(out_valid), .out_data(out_data)
  );

endmodule

// ----- hw/rtl/slc_checker.sv -----
// Port-level assertions for the cache model, bound to the top level.
module slc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          busy,
  input logic          out_valid,
  input slc_pkg::out_t out_data
);

  // Reset starts the clearing sweep
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // First result of a modify is followed at once by the second
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid && out_data.last)
    else $error("second access result missing");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.evicted)
    else $error("hit reported an eviction");

  // No result right after reset
  a_quiet_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind set_assoc_lru_cache_sim slc_checker u_slc_checker (.*);

// ----- bench/tb_set_assoc_lru_cache_sim.sv -----
// Self-checking bench for the set-associative LRU cache model: table-driven, then random traffic.
module tb_set_assoc_lru_cache_sim;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = 256;
  localparam int NWAYS = 8;
  localparam int DRAIN = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  slc_pkg::in_t in_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [slc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  slc_pkg::out_t out_data;

  set_assoc_lru_cache_sim dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Predicted cache state
  logic [3:0] cur_sets, cur_ways;
  logic [4:0] cur_block;
  bit line_ok [NSETS*NWAYS];
  logic [63:0] line_tg [NSETS*NWAYS];
  logic [31:0] line_ag [NSETS*NWAYS];
  logic [31:0] hits_n, miss_n, evict_n;

  slc_pkg::out_t pending_q[$];
  int errors = 0;
  int n_results = 0;
  int n_hits_seen = 0;
  int n_evicts_seen = 0;

  function automatic logic [31:0] sat_up(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Look up one address, update LRU state and counters, return the access outcome
  function automatic slc_pkg::out_t cache_access(logic [63:0] addr, bit fin);
    int s, b, w, base, victim, j, k;
    bit found, have_inv, have_old;
    logic [31:0] eldest;
    logic [63:0] tg;
    slc_pkg::out_t r;
    s = cur_sets;
    while (s > 1 && (1 << s) > NSETS) s--;
    if (s < 1) s = 1;
    b = cur_block;
    if (b < 1) b = 1;
    if (b > slc_pkg::BLOCK_MAX) b = slc_pkg::BLOCK_MAX;
    w = cur_ways;
    if (w < 1) w = 1;
    if (w > NWAYS) w = NWAYS;
    tg = addr >> (s + b);
    base = int'((addr >> b) & ((64'd1 << s) - 1)) * NWAYS;
    found = 0; have_inv = 0; have_old = 0; victim = 0; eldest = 0;
    for (j = 0; j < w; j++) begin
      k = base + j;
      if (!line_ok[k]) begin
        victim = j;
        have_inv = 1;
      end else if (line_tg[k] == tg) begin
        line_ag[k] = 0;
        found = 1;
      end else begin
        line_ag[k] = sat_up(line_ag[k]);
        if (!have_inv && (!have_old || line_ag[k] > eldest)) begin
          victim = j;
          eldest = line_ag[k];
          have_old = 1;
        end
      end
    end
    r = '0;
    r.hit = found;
    r.last = fin;
    if (found) hits_n = sat_up(hits_n);
    else begin
      miss_n = sat_up(miss_n);
      if (!have_inv) begin
        r.evicted = 1'b1;
        evict_n = sat_up(evict_n);
      end
      line_ok[base + victim] = 1;
      line_tg[base + victim] = tg;
      line_ag[base + victim] = 0;
    end
    r.hit_count = hits_n;
    r.miss_count = miss_n;
    r.eviction_count = evict_n;
    return r;
  endfunction

  // Queue the results one operation should produce
  task automatic predict_op(slc_pkg::in_t it);
    if (it.kind == slc_pkg::KIND_MODIFY) begin
      pending_q.push_back(cache_access(it.address, 0));
      pending_q.push_back(cache_access(it.address, 1));
    end else if (it.kind != slc_pkg::KIND_UNUSED) begin
      pending_q.push_back(cache_access(it.address, 1));
    end
  endtask

  // Compare every result against the oldest expectation
  always @(posedge clk) begin
    slc_pkg::out_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (out_data.hit) n_hits_seen++;
      if (out_data.evicted) n_evicts_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        e = pending_q.pop_front();
        if (out_data !== e) begin
          errors++;
          $display("%0t: mismatch hit %b/%b ev %b/%b last %b/%b hc %0d/%0d mc %0d/%0d ec %0d/%0d",
                   $time, e.hit, out_data.hit, e.evicted, out_data.evicted, e.last,
                   out_data.last, e.hit_count, out_data.hit_count, e.miss_count,
                   out_data.miss_count, e.eviction_count, out_data.eviction_count);
        end
      end
    end
  end

  bit gaps_on = 1;

  // Present one item and wait until taken; with gaps_on, idle for a random burst now and then
  task automatic send_op(slc_pkg::in_t it);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_op(it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      in_data <= '0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    release_start();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [slc_pkg::CFG_IDX_W-1:0] idx,
                           logic [slc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == slc_pkg::CFG_SET_BITS) cur_sets = val[3:0];
    else if (idx == slc_pkg::CFG_BLOCK_BITS) cur_block = val;
    else if (idx == slc_pkg::CFG_WAYS_USED) cur_ways = val[3:0];
  endtask

  // Write all three registers back to back, then drop valid
  task automatic set_geometry(logic [4:0] sb, logic [4:0] bb, logic [4:0] wy);
    write_reg(slc_pkg::CFG_SET_BITS, sb);
    write_reg(slc_pkg::CFG_BLOCK_BITS, bb);
    write_reg(slc_pkg::CFG_WAYS_USED, wy);
    cfg_valid <= 1'b0;
  endtask

  // Directed rows: operation, address, and a typed expectation where obvious
  typedef struct {
    logic [1:0] kind;
    logic [63:0] addr;
    bit known;
    logic hit;
    logic evicted;
  } row_t;

  row_t rows[] = '{
    '{slc_pkg::KIND_LOAD,   64'h0,                  1, 0, 0},
    '{slc_pkg::KIND_LOAD,   64'h0,                  1, 1, 0},
    '{slc_pkg::KIND_STORE,  64'hF,                  1, 1, 0},
    '{slc_pkg::KIND_UNUSED, 64'h0,                  0, 0, 0},
    '{slc_pkg::KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0},
    '{slc_pkg::KIND_LOAD,   64'h100,                0, 0, 0},
    '{slc_pkg::KIND_LOAD,   64'h0,                  0, 0, 0},
    '{slc_pkg::KIND_STORE,  64'h8000_0000_0000_0000, 0, 0, 0},
    '{slc_pkg::KIND_MODIFY, 64'h10,                 0, 0, 0},
    '{slc_pkg::KIND_LOAD,   64'hAAAA_5555_AAAA_5555, 0, 0, 0},
    '{slc_pkg::KIND_LOAD,   64'h5555_AAAA_5555_AAAA, 0, 0, 0}
  };

  logic [63:0] hot [16];

  function automatic slc_pkg::in_t rand_op(int depth);
    slc_pkg::in_t it;
    int r;
    r = $urandom_range(0, 99);
    it.kind = (r < 3) ? slc_pkg::KIND_UNUSED : 2'($urandom_range(0, 2));
    // Reuse a small pool so hits and LRU evictions are frequent
    if ($urandom_range(0, 9) < depth)
      it.address = hot[$urandom_range(0, 15)] ^ 64'($urandom_range(0, 15));
    else
      it.address = {$urandom, $urandom};
    return it;
  endfunction

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("** set_assoc_lru_cache_sim: FAILED **");
    $finish;
  end

  initial begin
    slc_pkg::in_t it;
    slc_pkg::out_t e;
    int i, ph;
    logic [4:0] sb, bb, wy;
    cur_sets = 4; cur_block = 4; cur_ways = 1;
    foreach (line_ok[i]) begin
      line_ok[i] = 0;
      line_tg[i] = '0;
      line_ag[i] = '0;
    end
    hits_n = 0; miss_n = 0; evict_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table under the reset geometry
    gaps_on = 0;
    foreach (rows[i]) begin
      it.kind = rows[i].kind;
      it.address = rows[i].addr;
      send_op(it);
      // The newest expectation belongs to the item just taken
      if (rows[i].known && pending_q.size() != 0) begin
        e = pending_q[$];
        if (e.hit !== rows[i].hit || e.evicted !== rows[i].evicted) begin
          errors++;
          $display("%0t: table row %0d expected hit %b ev %b, got hit %b ev %b",
                   $time, i, rows[i].hit, rows[i].evicted, e.hit, e.evicted);
        end
      end
    end
    wait_drain();

    // Extremes and out-of-range register values
    set_geometry(5'd15, 5'd31, 5'd15);
    for (i = 0; i < 12; i++) begin
      it.kind = 2'(i % 3);
      it.address = (i < 6) ? 64'(i) << 24 : ~(64'(i) << 24);
      send_op(it);
    end
    wait_drain();
    set_geometry(5'd0, 5'd0, 5'd0);
    for (i = 0; i < 8; i++) begin
      it.kind = 2'(i % 3);
      it.address = 64'(i) << 2;
      send_op(it);
    end
    wait_drain();

    // Random phases over several geometries; the last has no idling
    gaps_on = 1;
    for (ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin sb = 1; bb = 1; wy = 1; end
      else if (ph == 1) begin sb = 8; bb = 16; wy = 8; end
      else if (ph == 2) begin sb = 9; bb = 17; wy = 9; end
      else begin
        sb = 5'($urandom_range(0, 15));
        bb = 5'($urandom_range(0, 31));
        wy = 5'($urandom_range(0, 15));
      end
      set_geometry(sb, bb, wy);
      foreach (hot[i]) hot[i] = {$urandom, $urandom};
      if (ph == 9) gaps_on = 0;
      for (i = 0; i < 165; i++) begin
        send_op(rand_op($urandom_range(5, 9)));
        // Once, in phase 4, hold off until the queue of expectations is empty
        if (i == 80 && ph == 4) begin
          release_start();
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
      wait_drain();
    end

    $display("Ran %0d results (%0d hits, %0d evictions) over 13 geometries incl. clamps.",
             n_results, n_hits_seen, n_evicts_seen);
    if (errors == 0 && pending_q.size() == 0)
      $display("** set_assoc_lru_cache_sim: PASSED **");
    else
      $display("** set_assoc_lru_cache_sim: FAILED **");
    $finish;
  end
endmodule
